// ===== sv/bba_pkg.sv =====
package bba_pkg;

	localparam int POOL_BYTES_DEF = 65536;
	localparam int MIN_BLOCK_DEF  = 64;

	// granule entry: bit 0 block start, bit 1 free, bits 6:2 log2 size in granules
	localparam int OW = 5;
	localparam int EW = 7;

	localparam logic [1:0] OPC_ALLOC   = 2'd0;
	localparam logic [1:0] OPC_FREE    = 2'd1;
	localparam logic [1:0] OPC_REALLOC = 2'd2;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_LIMIT    = 3'd1,
		ST_NOPOOL   = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_NULL     = 3'd4
	} bba_st_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLR,
		OP_LOAD,
		OP_FIND_RD,
		OP_KEEP,
		OP_SAME,
		OP_INIT,
		OP_SCAN_START,
		OP_SCAN_RD,
		OP_SCAN_EVAL,
		OP_SPLIT_LOAD,
		OP_GROW_START,
		OP_GROW_MARK,
		OP_SPLIT_STEP,
		OP_SPLIT_FIN,
		OP_REL_START,
		OP_REL_RD,
		OP_REL_CLR,
		OP_REL_MARK,
		OP_EMIT
	} bba_op_t;

	typedef struct packed {
		bba_op_t op;
		logic    set_st;
		bba_st_t st;
	} bba_cmd_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic       has;
		logic       size_zero;
		logic       addr_ok;
		logic       lim_bad;
		logic       too_big;
		logic       heap_empty;
		logic       scan_end;
		logic       found;
		logic       ent_start;
		logic       ent_free;
		logic       ent_ord_eq;
		logic       ent_exact;
		logic       grow_bad;
		logic       grow_more;
		logic       split_more;
		logic       rel_top;
		logic       buddy_ok;
		logic       clr_last;
	} bba_stat_t;

endpackage

// ===== sv/bba_dp.sv =====
module bba_dp #(
	parameter int POOL_BYTES = bba_pkg::POOL_BYTES_DEF,
	parameter int MIN_BLOCK  = bba_pkg::MIN_BLOCK_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [16:0]         cfg_data,
	input  logic [1:0]          opcode,
	input  logic [16:0]         request_size,
	input  logic                has_address,
	input  logic [16:0]         data_address,
	input  bba_pkg::bba_cmd_t   cmd,
	output bba_pkg::bba_stat_t  stat,
	output logic                done,
	output logic [2:0]          status,
	output logic [16:0]         result_address
);

	localparam int GRANULES = POOL_BYTES / MIN_BLOCK;
	localparam int LOG_G    = $clog2(GRANULES);
	localparam int GW       = (LOG_G < 1) ? 1 : LOG_G;
	localparam int MW       = $clog2(MIN_BLOCK);
	localparam int XW       = (GW + MW + 1 > 18) ? GW + MW + 1 : 18;
	localparam int OW       = bba_pkg::OW;
	localparam int EW       = bba_pkg::EW;
	localparam logic [OW-1:0] LOG_G_O = OW'(LOG_G);
	localparam logic [GW:0]   GEND    = (GW+1)'(GRANULES);

	localparam logic [1:0] CFG_MIN = 2'd0;
	localparam logic [1:0] CFG_MAX = 2'd1;
	localparam logic [1:0] CFG_EN  = 2'd2;
	localparam logic [1:0] CFG_HDR = 2'd3;

	function automatic logic [EW-1:0] mark(input logic [OW-1:0] ord, input logic free);
		return {ord, free, 1'b1};
	endfunction

	// order of the smallest power-of-two block (>= MIN_BLOCK) holding t bytes
	function automatic logic [OW-1:0] order_for(input logic [17:0] t);
		logic [17:0] tm;
		logic [4:0]  cl;
		tm = t - 18'd1;
		cl = '0;
		for (int i = 0; i < 18; i++) begin
			if (tm[i]) cl = 5'(i + 1);
		end
		if (t <= 18'(MIN_BLOCK)) return '0;
		return OW'(cl - 5'(MW));
	endfunction

	logic [16:0]      min_q, max_q;
	logic             maxen_q;
	logic [7:0]       hdr_q;
	logic [1:0]       opc_q;
	logic [16:0]      size_q, daddr_q;
	logic             has_q;
	logic [OW-1:0]    rqo_q, hord_q, bo_q, wo_q, oo_q, gc_q, rlo_q;
	logic             hempty_q, found_q;
	logic [GW:0]      g_q, clr_q;
	logic [GW-1:0]    best_q, wg_q, og_q, rg_q;
	bba_pkg::bba_st_t status_q, out_st_q;
	logic [16:0]      addr_q, out_addr_q;
	logic             done_q;

	logic [EW-1:0]    mem [GRANULES];
	logic [EW-1:0]    rd_q;
	logic             mem_we;
	logic [GW-1:0]    mem_waddr, mem_raddr;
	logic [EW-1:0]    mem_wdata;

	logic [XW-1:0]    daddr_x, hdr_x, base_x, bg_x;
	logic             addr_ok;
	logic [GW-1:0]    gidx;
	logic [GW:0]      heap_g, step;
	logic [OW:0]      h1, r1, endord;
	logic [OW-1:0]    ent_ord, wo_m1, rlo_p1;
	logic [GW-1:0]    rel_bit;
	logic [XW-1:0]    blk_addr;

	always_comb begin
		daddr_x  = XW'(daddr_q);
		hdr_x    = XW'(hdr_q);
		base_x   = daddr_x - hdr_x;
		bg_x     = base_x >> MW;
		addr_ok  = (daddr_x >= hdr_x) && (base_x[MW-1:0] == '0) && !hempty_q
			&& ((bg_x >> hord_q) == '0);
		gidx     = bg_x[GW-1:0];
		heap_g   = (GW+1)'(1) << hord_q;
		ent_ord  = rd_q[EW-1:2];
		step     = (GW+1)'(1) << ent_ord;
		h1       = (OW+1)'(hord_q) + (OW+1)'(1);
		r1       = (OW+1)'(rqo_q) + (OW+1)'(1);
		endord   = (h1 > r1) ? h1 : r1;
		wo_m1    = wo_q - OW'(1);
		rlo_p1   = rlo_q + OW'(1);
		rel_bit  = GW'(1) << rlo_q;
		blk_addr = (XW'(wg_q) << MW) + hdr_x;
	end

	always_comb begin
		stat.opcode     = opc_q;
		stat.has        = has_q;
		stat.size_zero  = (size_q == '0);
		stat.addr_ok    = addr_ok;
		stat.lim_bad    = (size_q < min_q) || (maxen_q && (size_q > max_q));
		stat.too_big    = rqo_q > LOG_G_O;
		stat.heap_empty = hempty_q;
		stat.scan_end   = g_q >= heap_g;
		stat.found      = found_q;
		stat.ent_start  = rd_q[0];
		stat.ent_free   = rd_q[1];
		stat.ent_ord_eq = ent_ord == rqo_q;
		stat.ent_exact  = rd_q[0] && rd_q[1] && (ent_ord == rqo_q);
		stat.grow_bad   = endord > (OW+1)'(LOG_G);
		stat.grow_more  = gc_q < wo_q;
		stat.split_more = wo_q > rqo_q;
		stat.rel_top    = rlo_q >= hord_q;
		stat.buddy_ok   = rd_q[0] && rd_q[1] && (ent_ord == rlo_q);
		stat.clr_last   = clr_q == (GEND - (GW+1)'(1));
	end

	// table port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_raddr = '0;
		unique case (cmd.op)
			bba_pkg::OP_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q[GW-1:0];
			end
			bba_pkg::OP_FIND_RD: mem_raddr = gidx;
			bba_pkg::OP_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = mark(rqo_q, 1'b0);
			end
			bba_pkg::OP_SCAN_RD: mem_raddr = g_q[GW-1:0];
			bba_pkg::OP_GROW_MARK: begin
				mem_we    = 1'b1;
				mem_waddr = GW'(1) << gc_q;
				mem_wdata = mark(gc_q, 1'b1);
			end
			bba_pkg::OP_SPLIT_STEP: begin
				mem_we    = 1'b1;
				mem_waddr = wg_q + (GW'(1) << wo_m1);
				mem_wdata = mark(wo_m1, 1'b1);
			end
			bba_pkg::OP_SPLIT_FIN: begin
				mem_we    = 1'b1;
				mem_waddr = wg_q;
				mem_wdata = mark(rqo_q, 1'b0);
			end
			bba_pkg::OP_REL_START: begin
				mem_we    = 1'b1;
				mem_waddr = og_q;
				mem_wdata = mark(oo_q, 1'b1);
			end
			bba_pkg::OP_REL_RD: mem_raddr = rg_q ^ rel_bit;
			bba_pkg::OP_REL_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = rg_q | rel_bit;
			end
			bba_pkg::OP_REL_MARK: begin
				mem_we    = 1'b1;
				mem_waddr = rg_q & ~rel_bit;
				mem_wdata = mark(rlo_p1, 1'b1);
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q   <= '0;
			max_q   <= 17'd65536;
			maxen_q <= 1'b0;
			hdr_q   <= 8'd32;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MIN: min_q   <= cfg_data;
				CFG_MAX: max_q   <= cfg_data;
				CFG_EN:  maxen_q <= cfg_data[0];
				CFG_HDR: hdr_q   <= cfg_data[7:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opc_q      <= '0;
			size_q     <= '0;
			has_q      <= 1'b0;
			daddr_q    <= '0;
			rqo_q      <= '0;
			hord_q     <= '0;
			hempty_q   <= 1'b1;
			g_q        <= '0;
			found_q    <= 1'b0;
			best_q     <= '0;
			bo_q       <= '0;
			wg_q       <= '0;
			wo_q       <= '0;
			og_q       <= '0;
			oo_q       <= '0;
			gc_q       <= '0;
			rg_q       <= '0;
			rlo_q      <= '0;
			clr_q      <= '0;
			status_q   <= bba_pkg::ST_OK;
			addr_q     <= '0;
			done_q     <= 1'b0;
			out_st_q   <= bba_pkg::ST_OK;
			out_addr_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.set_st) status_q <= cmd.st;
			unique case (cmd.op)
				bba_pkg::OP_CLR: clr_q <= clr_q + (GW+1)'(1);
				bba_pkg::OP_LOAD: begin
					opc_q   <= opcode;
					size_q  <= request_size;
					has_q   <= has_address;
					daddr_q <= data_address;
					rqo_q   <= order_for(18'(request_size) + 18'(hdr_q));
					addr_q  <= '0;
				end
				bba_pkg::OP_FIND_RD: og_q <= gidx;
				bba_pkg::OP_KEEP:    oo_q <= ent_ord;
				bba_pkg::OP_SAME:    addr_q <= daddr_q;
				bba_pkg::OP_INIT: begin
					hord_q   <= rqo_q;
					hempty_q <= 1'b0;
					addr_q   <= 17'(hdr_q);
				end
				bba_pkg::OP_SCAN_START: begin
					g_q     <= '0;
					found_q <= 1'b0;
				end
				bba_pkg::OP_SCAN_EVAL: begin
					if (!rd_q[0]) begin
						g_q <= g_q + (GW+1)'(1);
					end else if (rd_q[1] && ent_ord == rqo_q) begin
						best_q  <= g_q[GW-1:0];
						bo_q    <= ent_ord;
						found_q <= 1'b1;
					end else begin
						if (rd_q[1] && ent_ord > rqo_q && (!found_q || ent_ord < bo_q)) begin
							best_q  <= g_q[GW-1:0];
							bo_q    <= ent_ord;
							found_q <= 1'b1;
						end
						if (ent_ord > LOG_G_O) g_q <= GEND;
						else g_q <= g_q + step;
					end
				end
				bba_pkg::OP_SPLIT_LOAD: begin
					wg_q <= best_q;
					wo_q <= bo_q;
				end
				bba_pkg::OP_GROW_START: begin
					gc_q   <= hord_q;
					wo_q   <= OW'(endord - (OW+1)'(1));
					wg_q   <= GW'(1) << (endord - (OW+1)'(1));
					hord_q <= OW'(endord);
				end
				bba_pkg::OP_GROW_MARK:  gc_q <= gc_q + OW'(1);
				bba_pkg::OP_SPLIT_STEP: wo_q <= wo_m1;
				bba_pkg::OP_SPLIT_FIN:  addr_q <= blk_addr[16:0];
				bba_pkg::OP_REL_START: begin
					rg_q  <= og_q;
					rlo_q <= oo_q;
				end
				bba_pkg::OP_REL_MARK: begin
					rg_q  <= rg_q & ~rel_bit;
					rlo_q <= rlo_p1;
				end
				bba_pkg::OP_EMIT: begin
					done_q     <= 1'b1;
					out_st_q   <= status_q;
					out_addr_q <= (status_q == bba_pkg::ST_OK) ? addr_q : '0;
				end
				default: done_q <= 1'b0;
			endcase
		end
	end

	assign done           = done_q;
	assign status         = out_st_q;
	assign result_address = out_addr_q;

endmodule

// ===== sv/bba_ctrl.sv =====
module bba_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  bba_pkg::bba_stat_t stat,
	output logic               busy,
	output bba_pkg::bba_cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_FIND,
		S_SAME,
		S_ALLOC,
		S_SCAN_RD,
		S_SCAN_EV,
		S_SCAN_END,
		S_GROW,
		S_SPLIT,
		S_ALLOC_OK,
		S_REL_START,
		S_REL_CHK,
		S_REL_EV,
		S_REL_MARK,
		S_DONE
	} state_t;

	state_t st_q, nxt;

	always_comb begin
		nxt        = st_q;
		cmd.op     = bba_pkg::OP_NONE;
		cmd.set_st = 1'b0;
		cmd.st     = bba_pkg::ST_OK;
		unique case (st_q)
			S_CLEAR: begin
				cmd.op = bba_pkg::OP_CLR;
				if (stat.clr_last) nxt = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.op = bba_pkg::OP_LOAD;
					nxt    = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.opcode)
					bba_pkg::OPC_ALLOC: nxt = S_ALLOC;
					bba_pkg::OPC_FREE: begin
						if (stat.has && stat.addr_ok) begin
							cmd.op = bba_pkg::OP_FIND_RD;
							nxt    = S_FIND;
						end else begin
							cmd.set_st = 1'b1;
							cmd.st     = bba_pkg::ST_NOTFOUND;
							nxt        = S_DONE;
						end
					end
					bba_pkg::OPC_REALLOC: begin
						if (stat.size_zero) begin
							cmd.set_st = 1'b1;
							cmd.st     = bba_pkg::ST_NULL;
							if (stat.has && stat.addr_ok) begin
								cmd.op = bba_pkg::OP_FIND_RD;
								nxt    = S_FIND;
							end else begin
								nxt = S_DONE;
							end
						end else if (!stat.has) begin
							nxt = S_ALLOC;
						end else if (stat.addr_ok) begin
							cmd.op = bba_pkg::OP_FIND_RD;
							nxt    = S_FIND;
						end else begin
							cmd.set_st = 1'b1;
							cmd.st     = bba_pkg::ST_NOTFOUND;
							nxt        = S_DONE;
						end
					end
					default: begin
						cmd.set_st = 1'b1;
						cmd.st     = bba_pkg::ST_LIMIT;
						nxt        = S_DONE;
					end
				endcase
			end
			S_FIND: begin
				cmd.op = bba_pkg::OP_KEEP;
				if (stat.opcode == bba_pkg::OPC_FREE) begin
					cmd.set_st = 1'b1;
					if (stat.ent_start) begin
						cmd.st = bba_pkg::ST_OK;
						nxt    = S_REL_START;
					end else begin
						cmd.st = bba_pkg::ST_NOTFOUND;
						nxt    = S_DONE;
					end
				end else if (stat.size_zero) begin
					nxt = stat.ent_start ? S_REL_START : S_DONE;
				end else if (!stat.ent_start || stat.ent_free) begin
					cmd.set_st = 1'b1;
					cmd.st     = bba_pkg::ST_NOTFOUND;
					nxt        = S_DONE;
				end else if (stat.ent_ord_eq) begin
					nxt = S_SAME;
				end else begin
					nxt = S_ALLOC;
				end
			end
			S_SAME: begin
				cmd.op     = bba_pkg::OP_SAME;
				cmd.set_st = 1'b1;
				cmd.st     = bba_pkg::ST_OK;
				nxt        = S_DONE;
			end
			S_ALLOC: begin
				if (stat.lim_bad) begin
					cmd.set_st = 1'b1;
					cmd.st     = bba_pkg::ST_LIMIT;
					nxt        = S_DONE;
				end else if (stat.too_big) begin
					cmd.set_st = 1'b1;
					cmd.st     = bba_pkg::ST_NOPOOL;
					nxt        = S_DONE;
				end else if (stat.heap_empty) begin
					cmd.op     = bba_pkg::OP_INIT;
					cmd.set_st = 1'b1;
					cmd.st     = bba_pkg::ST_OK;
					nxt        = S_ALLOC_OK;
				end else begin
					cmd.op = bba_pkg::OP_SCAN_START;
					nxt    = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				if (stat.scan_end) begin
					nxt = S_SCAN_END;
				end else begin
					cmd.op = bba_pkg::OP_SCAN_RD;
					nxt    = S_SCAN_EV;
				end
			end
			S_SCAN_EV: begin
				cmd.op = bba_pkg::OP_SCAN_EVAL;
				nxt    = stat.ent_exact ? S_SCAN_END : S_SCAN_RD;
			end
			S_SCAN_END: begin
				if (stat.found) begin
					cmd.op = bba_pkg::OP_SPLIT_LOAD;
					nxt    = S_SPLIT;
				end else if (stat.grow_bad) begin
					cmd.set_st = 1'b1;
					cmd.st     = bba_pkg::ST_NOPOOL;
					nxt        = S_DONE;
				end else begin
					cmd.op = bba_pkg::OP_GROW_START;
					nxt    = S_GROW;
				end
			end
			S_GROW: begin
				if (stat.grow_more) cmd.op = bba_pkg::OP_GROW_MARK;
				else nxt = S_SPLIT;
			end
			S_SPLIT: begin
				if (stat.split_more) begin
					cmd.op = bba_pkg::OP_SPLIT_STEP;
				end else begin
					cmd.op     = bba_pkg::OP_SPLIT_FIN;
					cmd.set_st = 1'b1;
					cmd.st     = bba_pkg::ST_OK;
					nxt        = S_ALLOC_OK;
				end
			end
			S_ALLOC_OK: begin
				if (stat.opcode == bba_pkg::OPC_REALLOC && stat.has) nxt = S_REL_START;
				else nxt = S_DONE;
			end
			S_REL_START: begin
				cmd.op = bba_pkg::OP_REL_START;
				nxt    = S_REL_CHK;
			end
			S_REL_CHK: begin
				if (stat.rel_top) begin
					nxt = S_DONE;
				end else begin
					cmd.op = bba_pkg::OP_REL_RD;
					nxt    = S_REL_EV;
				end
			end
			S_REL_EV: begin
				if (stat.buddy_ok) begin
					cmd.op = bba_pkg::OP_REL_CLR;
					nxt    = S_REL_MARK;
				end else begin
					nxt = S_DONE;
				end
			end
			S_REL_MARK: begin
				cmd.op = bba_pkg::OP_REL_MARK;
				nxt    = S_REL_CHK;
			end
			S_DONE: begin
				cmd.op = bba_pkg::OP_EMIT;
				nxt    = S_IDLE;
			end
			default: nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLEAR;
		end else begin
			st_q <= nxt;
		end
	end

	assign busy = (st_q != S_IDLE);

endmodule

// ===== sv/buddy_block_allocator_unit.sv =====
// Buddy block allocator: hands out power-of-two blocks of a pool that grows
// by doubling, and frees or reallocates them with buddy merging.
// Command channel: an item (opcode, request_size, has_address, data_address)
// is taken at a rising edge with start high and busy low. busy stays high
// until the result transaction has been issued.
// Result channel: done is high for exactly one cycle with status and
// result_address; there is no back-pressure, the receiver must take it then.
// Config port: cfg_we / cfg_index / cfg_data write min_request, max_request,
// max_enabled, header_bytes (index 0..3). The user must write them only while
// busy is low; the block itself does not enforce it. Steps: a search reads
// and then evaluates the table entry of each block in the heap until an exact
// fit; the heap doubles when no block fits, the chosen block is halved to the
// request size, and a merge climbs one level at a time. The granule table has
// one read and one write port. Reset: the heap empties, registers take their
// defaults, and a clearing pass writes all POOL_BYTES/MIN_BLOCK table
// entries (1024 by default) with busy high; config writes are taken then.
module buddy_block_allocator_unit #(
	parameter int POOL_BYTES = bba_pkg::POOL_BYTES_DEF,
	parameter int MIN_BLOCK  = bba_pkg::MIN_BLOCK_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [16:0] request_size,
	input  logic        has_address,
	input  logic [16:0] data_address,
	output logic        done,
	output logic [2:0]  status,
	output logic [16:0] result_address
);

	bba_pkg::bba_cmd_t  cmd;
	bba_pkg::bba_stat_t stat;

	// sequencer: walks each request through lookup, search, split, grow, merge
	bba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	// table, heap state, config registers and result registers
	bba_dp #(
		.POOL_BYTES (POOL_BYTES),
		.MIN_BLOCK  (MIN_BLOCK)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.opcode         (opcode),
		.request_size   (request_size),
		.has_address    (has_address),
		.data_address   (data_address),
		.cmd            (cmd),
		.stat           (stat),
		.done           (done),
		.status         (status),
		.result_address (result_address)
	);

	// the result pulse comes as the sequencer drops back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result issued while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("more than one result for a command");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != bba_pkg::ST_OK) |-> (result_address == 17'd0))
		else $error("failed transaction carries an address");

endmodule

// ===== tb/buddy_block_allocator_unit_tb.sv =====
`timescale 1ns / 100ps

module buddy_block_allocator_unit_tb;

	localparam int unsigned POOL_BYTES = 65536;
	localparam int unsigned MIN_BLOCK  = 64;
	localparam int unsigned GRANULES   = POOL_BYTES / MIN_BLOCK;
	localparam int unsigned MAX_ORDER  = 24;
	// worst case: every item scans a full table of 1024 blocks, then some
	localparam longint CYCLE_LIMIT = 10_000_000;

	// register indexes of the config port
	localparam logic [1:0] REG_MIN_REQ = 2'd0;
	localparam logic [1:0] REG_MAX_REQ = 2'd1;
	localparam logic [1:0] REG_MAX_EN  = 2'd2;
	localparam logic [1:0] REG_HEADER  = 2'd3;

	// opcode 3 is not decoded; the block answers it with a limit status
	localparam logic [1:0] OPC_UNUSED = 2'd3;

	typedef struct {
		bba_pkg::bba_st_t st;
		logic [16:0]      addr;
	} alloc_reply_t;

	// directed row: typed reply only where it can be read off at a glance
	typedef struct {
		logic [1:0]       op;
		int unsigned      size;
		bit               has;
		int unsigned      addr;
		bit               typed;
		bba_pkg::bba_st_t st;
		int unsigned      exp_addr;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [16:0] cfg_data;
	logic        start;
	logic        busy;
	logic [1:0]  opcode;
	logic [16:0] request_size;
	logic        has_address;
	logic [16:0] data_address;
	logic        done;
	logic [2:0]  status;
	logic [16:0] result_address;

	buddy_block_allocator_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.request_size(request_size),
		.has_address(has_address),
		.data_address(data_address),
		.done(done),
		.status(status),
		.result_address(result_address)
	);

	// ---------------------------------------------------------------
	// Shadow allocator state
	// granule entry: bit 0 block start, bit 1 free, bits 6:2 log2 size
	// ---------------------------------------------------------------
	logic [6:0]  gran [GRANULES];
	int unsigned heap_bytes;
	int unsigned lim_min;
	int unsigned lim_max;
	int unsigned lim_en;
	int unsigned hdr;

	alloc_reply_t pending_replies[$];
	int unsigned  live_base[$];  // block starts believed allocated
	int           errors;
	longint       cycles;
	int           idle_pct;
	int           items_sent;

	function automatic int unsigned order_for(int unsigned bytes);
		int unsigned o;
		o = 0;
		while (o < MAX_ORDER && (MIN_BLOCK << o) < bytes)
			o++;
		return o;
	endfunction

	function automatic void tag_granule(int unsigned g, int unsigned ord, bit fr);
		if (g < GRANULES)
			gran[g] = {ord[4:0], fr, 1'b1};
	endfunction

	function automatic int unsigned round_block(int unsigned size);
		int unsigned t;
		int unsigned p;
		t = hdr + size;
		p = 1;
		while (p < t)
			p <<= 1;
		if (p < MIN_BLOCK)
			p = MIN_BLOCK;
		return p;
	endfunction

	// halve down to the target order, left half kept, right halves freed
	function automatic void split_block(int unsigned g, int unsigned ord,
			int unsigned target);
		while (ord > target) begin
			ord--;
			tag_granule(g + (1 << ord), ord, 1'b1);
		end
		tag_granule(g, ord, 1'b0);
	endfunction

	function automatic bba_pkg::bba_st_t carve_block(int unsigned size,
			output int unsigned addr);
		int unsigned req, ro, g, best, bo, cur, last, h, o;
		logic [6:0]  e;
		bit          found;
		addr = 0;
		best = 0;
		bo = 0;
		found = 0;
		if (size < lim_min || (lim_en != 0 && size > lim_max))
			return bba_pkg::ST_LIMIT;
		req = round_block(size);
		if (req > POOL_BYTES)
			return bba_pkg::ST_NOPOOL;
		ro = order_for(req);
		if (heap_bytes == 0) begin
			heap_bytes = req;
			tag_granule(0, ro, 1'b0);
			addr = hdr;
			return bba_pkg::ST_OK;
		end
		// best fit: exact size wins at once, else smallest larger, lowest address
		g = 0;
		while (g < GRANULES && g * MIN_BLOCK < heap_bytes) begin
			e = gran[g];
			if (!e[0]) begin
				g++;
				continue;
			end
			o = e[6:2];
			if (e[1]) begin
				if (o == ro) begin
					best = g;
					bo = o;
					found = 1;
					break;
				end
				if (o > ro && (!found || o < bo)) begin
					best = g;
					bo = o;
					found = 1;
				end
			end
			g += 1 << o;
		end
		if (found) begin
			split_block(best, bo, ro);
			addr = best * MIN_BLOCK + hdr;
			return bba_pkg::ST_OK;
		end
		// grow the heap by doubling until the new right block fits
		h = heap_bytes;
		do
			h <<= 1;
		while (h / 2 < req && h <= POOL_BYTES);
		if (h > POOL_BYTES)
			return bba_pkg::ST_NOPOOL;
		cur = heap_bytes;
		last = cur;
		do begin
			tag_granule(cur / MIN_BLOCK, order_for(cur), 1'b1);
			last = cur;
			cur <<= 1;
		end while (cur / 2 < req);
		heap_bytes = cur;
		split_block(last / MIN_BLOCK, order_for(last), ro);
		addr = last + hdr;
		return bba_pkg::ST_OK;
	endfunction

	function automatic bit locate_block(int unsigned addr, output int unsigned g);
		int unsigned base;
		g = 0;
		if (addr < hdr)
			return 0;
		base = addr - hdr;
		if (base % MIN_BLOCK != 0 || base >= heap_bytes)
			return 0;
		if (base / MIN_BLOCK >= GRANULES)
			return 0;
		if (!gran[base / MIN_BLOCK][0])
			return 0;
		g = base / MIN_BLOCK;
		return 1;
	endfunction

	// mark free, then merge with the buddy while it is free and the same size
	function automatic void release_block(int unsigned g);
		int unsigned o, s, b, lo, hi;
		logic [6:0]  e;
		o = gran[g][6:2];
		tag_granule(g, o, 1'b1);
		while (1) begin
			if (o >= MAX_ORDER)
				break;
			s = 1 << o;
			if (s * MIN_BLOCK >= heap_bytes)
				break;
			b = g ^ s;
			if (b >= GRANULES)
				break;
			e = gran[b];
			if (!e[0] || !e[1] || e[6:2] != o)
				break;
			lo = g < b ? g : b;
			hi = g < b ? b : g;
			gran[hi] = '0;
			o++;
			tag_granule(lo, o, 1'b1);
			g = lo;
		end
	endfunction

	function automatic alloc_reply_t serve_request(logic [1:0] op, int unsigned size,
			bit has, int unsigned daddr);
		alloc_reply_t r;
		int unsigned  g, a, req, cur;
		a = 0;
		r.st = bba_pkg::ST_LIMIT;
		case (op)
			bba_pkg::OPC_ALLOC: begin
				r.st = carve_block(size, a);
			end
			bba_pkg::OPC_FREE: begin
				if (has && locate_block(daddr, g)) begin
					release_block(g);
					r.st = bba_pkg::ST_OK;
				end else
					r.st = bba_pkg::ST_NOTFOUND;
			end
			bba_pkg::OPC_REALLOC: begin
				if (size == 0) begin
					if (has && locate_block(daddr, g))
						release_block(g);
					r.st = bba_pkg::ST_NULL;
				end else if (!has) begin
					r.st = carve_block(size, a);
				end else if (!locate_block(daddr, g) || gran[g][1]) begin
					r.st = bba_pkg::ST_NOTFOUND;
				end else begin
					req = round_block(size);
					cur = MIN_BLOCK << gran[g][6:2];
					if (cur == req) begin
						r.st = bba_pkg::ST_OK;
						a = daddr;
					end else begin
						r.st = carve_block(size, a);
						if (r.st == bba_pkg::ST_OK)
							release_block(g);
					end
				end
			end
			default: r.st = bba_pkg::ST_LIMIT;
		endcase
		if (r.st != bba_pkg::ST_OK)
			a = 0;
		r.addr = a[16:0];
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Clock, reset, cycle limit
	// ---------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// Result checker: one done pulse per transaction, no back-pressure
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		alloc_reply_t exp_r;
		if (arst_n && done) begin
			if (pending_replies.size() == 0) begin
				$error("unexpected result: status %0d result_address %0d",
					status, result_address);
				errors++;
			end else begin
				exp_r = pending_replies.pop_front();
				if (status !== exp_r.st) begin
					$error("status: expected %0d, actual %0d", exp_r.st, status);
					errors++;
				end
				if (result_address !== exp_r.addr) begin
					$error("result_address: expected %0d, actual %0d",
						exp_r.addr, result_address);
					errors++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Driver tasks: inputs move on the falling edge
	// ---------------------------------------------------------------

	// wait for every reply and an idle block; start goes low first
	task automatic drain_replies();
		@(negedge clk);
		start <= 1'b0;
		while (pending_replies.size() != 0 || busy)
			@(posedge clk);
	endtask

	task automatic write_limits(int unsigned mn, int unsigned mx, int unsigned en,
			int unsigned hb);
		drain_replies();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_MIN_REQ;
		cfg_data <= mn[16:0];
		@(negedge clk);
		cfg_index <= REG_MAX_REQ;
		cfg_data <= mx[16:0];
		@(negedge clk);
		cfg_index <= REG_MAX_EN;
		cfg_data <= {16'd0, en[0]};
		@(negedge clk);
		cfg_index <= REG_HEADER;
		cfg_data <= {9'd0, hb[7:0]};
		@(negedge clk);
		cfg_we <= 1'b0;
		lim_min = mn & 17'h1FFFF;
		lim_max = mx & 17'h1FFFF;
		lim_en = en & 1;
		hdr = hb & 8'hFF;
	endtask

	// one command transaction; returns the predicted reply
	task automatic issue_request(logic [1:0] op, int unsigned size, bit has,
			int unsigned daddr, bit typed, bba_pkg::bba_st_t tst, int unsigned taddr,
			output alloc_reply_t r);
		alloc_reply_t t;
		int           gap;
		@(negedge clk);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			gap = $urandom_range(1, 8);
			repeat (gap - 1) @(negedge clk);
			@(negedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		request_size <= size[16:0];
		has_address <= has;
		data_address <= daddr[16:0];
		do
			@(posedge clk);
		while (busy);
		r = serve_request(op, size, has, daddr);
		if (typed) begin
			t.st = tst;
			t.addr = taddr[16:0];
			pending_replies.push_back(t);
		end else
			pending_replies.push_back(r);
		items_sent++;
		// idling profile shifts with progress: 31%, then 70%, then none
		if (items_sent < 283)
			idle_pct = 31;
		else if (items_sent < 566)
			idle_pct = 70;
		else
			idle_pct = 0;
	endtask

	function automatic int unsigned pick_size();
		int unsigned k;
		k = $urandom_range(99);
		if (k < 75)
			return $urandom_range(0, 400);
		else if (k < 93)
			return $urandom_range(0, 4000);
		else if (k < 97)
			return $urandom_range(0, 65536);
		else
			return 65536 - $urandom_range(0, 40);
	endfunction

	// random traffic, mostly alloc / free / realloc of live blocks
	task automatic random_traffic(int n);
		alloc_reply_t r;
		int unsigned  k, idx, sz, base;
		logic [1:0]   op;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(99);
			// keep the live set bounded so scans stay short
			if (live_base.size() > 48 && k < 40)
				k = 50;
			if (live_base.size() == 0 && k >= 40 && k < 85)
				k = 0;
			if (k < 40) begin
				issue_request(bba_pkg::OPC_ALLOC, pick_size(), $urandom_range(1),
					$urandom_range(0, 65791), 0, bba_pkg::ST_OK, 0, r);
				if (r.st == bba_pkg::ST_OK)
					live_base.push_back(r.addr - hdr);
			end else if (k < 70) begin
				idx = $urandom_range(0, live_base.size() - 1);
				base = live_base[idx];
				issue_request(bba_pkg::OPC_FREE, $urandom_range(0, 65536), 1'b1,
					base + hdr, 0, bba_pkg::ST_OK, 0, r);
				if (r.st == bba_pkg::ST_OK)
					live_base.delete(idx);
			end else if (k < 85) begin
				idx = $urandom_range(0, live_base.size() - 1);
				base = live_base[idx];
				sz = ($urandom_range(9) == 0) ? 0 : pick_size();
				issue_request(bba_pkg::OPC_REALLOC, sz, 1'b1, base + hdr, 0,
					bba_pkg::ST_OK, 0, r);
				if (r.st == bba_pkg::ST_NULL)
					live_base.delete(idx);
				else if (r.st == bba_pkg::ST_OK)
					live_base[idx] = r.addr - hdr;
			end else if (k < 90) begin
				issue_request(bba_pkg::OPC_REALLOC, pick_size(), 1'b0,
					$urandom_range(0, 65791), 0, bba_pkg::ST_OK, 0, r);
				if (r.st == bba_pkg::ST_OK)
					live_base.push_back(r.addr - hdr);
			end else begin
				// noise: stray addresses, null pointers, the unused opcode
				op = (k < 97) ? bba_pkg::OPC_FREE :
					((k < 99) ? bba_pkg::OPC_REALLOC : OPC_UNUSED);
				issue_request(op, pick_size(), $urandom_range(1),
					$urandom_range(0, 65791), 0, bba_pkg::ST_OK, 0, r);
			end
		end
	endtask

	// ---------------------------------------------------------------
	// Directed rows, default limits and a 32-byte header
	// ---------------------------------------------------------------
	dir_row_t dir_rows[] = '{
		'{bba_pkg::OPC_ALLOC, 0, 0, 0, 1, bba_pkg::ST_OK, 32}, // empty heap, zero size
		'{bba_pkg::OPC_ALLOC, 65536, 0, 0, 1, bba_pkg::ST_NOPOOL, 0}, // rounds past pool
		'{bba_pkg::OPC_FREE, 0, 0, 0, 1, bba_pkg::ST_NOTFOUND, 0}, // free of null
		'{bba_pkg::OPC_FREE, 0, 1, 12345, 1, bba_pkg::ST_NOTFOUND, 0}, // unknown address
		'{OPC_UNUSED, 0, 1, 0, 1, bba_pkg::ST_LIMIT, 0}, // unused opcode
		'{bba_pkg::OPC_REALLOC, 0, 0, 0, 1, bba_pkg::ST_NULL, 0}, // realloc to zero, null
		'{bba_pkg::OPC_ALLOC, 100, 0, 0, 0, bba_pkg::ST_OK, 0}, // heap doubles three times
		'{bba_pkg::OPC_ALLOC, 1000, 0, 0, 0, bba_pkg::ST_OK, 0},
		'{bba_pkg::OPC_REALLOC, 200, 0, 0, 0, bba_pkg::ST_OK, 0}, // null acts as alloc
		'{bba_pkg::OPC_REALLOC, 20, 1, 32, 1, bba_pkg::ST_OK, 32}, // same rounded size
		'{bba_pkg::OPC_REALLOC, 500, 1, 32, 0, bba_pkg::ST_OK, 0}, // moves, old freed
		'{bba_pkg::OPC_FREE, 0, 1, 32, 0, bba_pkg::ST_OK, 0}, // free of a free block
		'{bba_pkg::OPC_REALLOC, 10, 1, 32, 1, bba_pkg::ST_NOTFOUND, 0}, // of free block
		'{bba_pkg::OPC_FREE, 0, 1, 96, 0, bba_pkg::ST_OK, 0},
		'{bba_pkg::OPC_ALLOC, 65504, 0, 0, 0, bba_pkg::ST_OK, 0}, // growth past the pool
		'{bba_pkg::OPC_ALLOC, 32000, 0, 0, 0, bba_pkg::ST_OK, 0},
		'{bba_pkg::OPC_FREE, 0, 1, 65791, 1, bba_pkg::ST_NOTFOUND, 0}, // top address
		'{bba_pkg::OPC_ALLOC, 65535, 1, 0, 0, bba_pkg::ST_OK, 0},
		'{bba_pkg::OPC_REALLOC, 0, 1, 288, 0, bba_pkg::ST_OK, 0} // realloc to zero
	};

	initial begin
		alloc_reply_t r;
		errors = 0;
		items_sent = 0;
		idle_pct = 31;
		for (int i = 0; i < GRANULES; i++)
			gran[i] = '0;
		heap_bytes = 0;
		lim_min = 0;
		lim_max = 65536;
		lim_en = 0;
		hdr = 32;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_MIN_REQ;
		cfg_data = '0;
		start = 1'b0;
		opcode = bba_pkg::OPC_ALLOC;
		request_size = '0;
		has_address = 1'b0;
		data_address = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// the clearing pass after reset keeps busy high; drain waits it out
		write_limits(0, 65536, 0, 32);
		foreach (dir_rows[i]) begin
			issue_request(dir_rows[i].op, dir_rows[i].size, dir_rows[i].has,
				dir_rows[i].addr, dir_rows[i].typed, dir_rows[i].st,
				dir_rows[i].exp_addr, r);
			if (dir_rows[i].op != bba_pkg::OPC_FREE && r.st == bba_pkg::ST_OK
					&& r.addr != 0)
				live_base.push_back(r.addr - hdr);
		end
		random_traffic(200);

		// no header, upper limit on
		write_limits(0, 65535, 1, 0);
		random_traffic(200);

		// widest header, tight window of sizes
		write_limits(17, 3000, 1, 255);
		random_traffic(200);

		// extremes: only the largest size passes the lower limit
		write_limits(65536, 0, 0, 7);
		random_traffic(30);

		write_limits(0, 65536, 1, 128);
		random_traffic(200);

		drain_replies();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending_replies.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
